// ===== design/triangle_unit_normal_core_defines.svh =====
// Assertion macros for the triangle normal design.
`ifndef TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define TUN_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent.
`define TUN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tun_pkg.sv =====
// Constants for the triangle unit normal pipeline.
package tun_pkg;
  localparam int IDX_W     = 32;
  localparam int NORM_W    = 32;
  localparam int FRAC_BITS = 30;
  localparam int ITERS     = FRAC_BITS + 1;
  localparam int RHS_SHIFT = 2 * (FRAC_BITS + 1);
  localparam int PRE_ST    = 6;
endpackage

// ===== design/triangle_unit_normal_core.sv =====
// Triangle unit normal: takes one triangle a request and returns its rounded unit face normal.
// Each request carries three vertices in signed fixed point and a 32-bit tag. The block forms
// the edges b-a and c-a, their exact cross product and its squared length, then finds each
// Q1.30 component bit by bit, one bit per pipeline stage, rounding to nearest with ties away
// from zero. A zero cross product yields zero components with the degenerate flag (tuser) set.
// One request is accepted per cycle while the output is not stalled; the pipeline is made of the
// six arithmetic stages, the 31 result-bit stages and the output register. Valid bits ride with the
// data and each stage advances when it is empty or the stage after it moves, so stalls collapse bubbles.
`include "triangle_unit_normal_core_defines.svh"

module triangle_unit_normal_core
  import tun_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // tri_index, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero fill
  input  logic [((IDX_W + 9 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // out_index, norm_x, norm_y, norm_z
  output logic [IDX_W + 3 * NORM_W - 1:0] m_tdata,
  // degenerate
  output logic m_tuser
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int NW  = 2 * DW + 1;
  localparam int MW  = 2 * DW;
  localparam int H   = DW;
  localparam int QW  = 2 * MW;
  localparam int SW  = QW + 2;
  localparam int RW  = QW + RHS_SHIFT + 4;
  localparam int PW  = SW + 33;
  localparam int NST = PRE_ST + ITERS + 1;
  localparam int OST = NST - 1;

  logic [NST-1:0] vld;
  logic [NST:0]   en;
  logic [IDX_W-1:0] idx [NST];

  // stage 0: edge vectors
  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] v [3];
  // stage 1: cross product terms
  logic signed [2*DW-1:0] prod [6];
  // stage 2: cross product
  logic signed [NW-1:0] nrm [3];
  // stage 3: partial squares
  logic [2*H-1:0] hh [3];
  logic [2*H-1:0] hl [3];
  logic [2*H-1:0] ll [3];
  logic [2:0] neg3;
  // stage 4: squares
  logic [QW-1:0] sq [3];
  logic [2:0] neg4;
  // stages 5 to 36: remainder, odd times length, result bits
  logic signed [RW-1:0] rr [ITERS+1][3];
  logic signed [PW-1:0] pp [ITERS+1][3];
  logic [ITERS-1:0] kk [ITERS+1][3];
  logic [SW-1:0] ssum [ITERS+1];
  logic [2:0] negi [ITERS+1];
  logic deg [ITERS+1];
  // output stage
  logic [NORM_W-1:0] norm [3];
  logic deg_out;

  logic signed [DW-1:0] crd [9];
  logic [MW-1:0] mag [3];
  logic [SW-1:0] s_in;

  always_comb begin
    en[NST] = m_tready;
    for (int i = NST - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[OST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // tag shift line
  always_ff @(posedge clk) begin
    if (en[0]) begin
      idx[0] <= s_tdata[IDX_W-1:0];
    end
    for (int i = 1; i < NST; i++) begin
      if (en[i]) begin
        idx[i] <= idx[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      crd[i] = DW'($signed(s_tdata[IDX_W + i*CW +: CW]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < 3; l++) begin
        u[l] <= crd[3+l] - crd[l];
        v[l] <= crd[6+l] - crd[l];
      end
    end
    if (en[1]) begin
      prod[0] <= u[1] * v[2];
      prod[1] <= u[2] * v[1];
      prod[2] <= u[2] * v[0];
      prod[3] <= u[0] * v[2];
      prod[4] <= u[0] * v[1];
      prod[5] <= u[1] * v[0];
    end
    if (en[2]) begin
      for (int l = 0; l < 3; l++) begin
        nrm[l] <= NW'(prod[2*l]) - NW'(prod[2*l+1]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = nrm[l][NW-1] ? MW'(-nrm[l]) : MW'(nrm[l]);
    end
  end

  // split each square into narrow partial products
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int l = 0; l < 3; l++) begin
        hh[l]   <= mag[l][MW-1:H] * mag[l][MW-1:H];
        hl[l]   <= mag[l][MW-1:H] * mag[l][H-1:0];
        ll[l]   <= mag[l][H-1:0] * mag[l][H-1:0];
        neg3[l] <= nrm[l][NW-1];
      end
    end
    if (en[4]) begin
      for (int l = 0; l < 3; l++) begin
        sq[l] <= (QW'(hh[l]) << MW) + (QW'(hl[l]) << (H + 1)) + QW'(ll[l]);
      end
      neg4 <= neg3;
    end
  end

  assign s_in = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);

  // seed: odd value of minus one
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int l = 0; l < 3; l++) begin
        rr[0][l] <= (RW'(sq[l]) << RHS_SHIFT) - RW'(s_in);
        pp[0][l] <= PW'(0) - PW'(s_in);
        kk[0][l] <= '0;
      end
      ssum[0] <= s_in;
      negi[0] <= neg4;
      deg[0]  <= (s_in == '0);
    end
  end

  for (genvar j = 1; j <= ITERS; j++) begin : g_bit
    localparam int B = ITERS - j;
    logic signed [RW-1:0] dif [3];
    logic [2:0] take;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        dif[l]  = rr[j-1][l] - ((RW'(pp[j-1][l]) <<< (B + 2))
                               + (RW'(ssum[j-1]) << (2 * B + 2)));
        take[l] = !dif[l][RW-1] && !kk[j-1][l][ITERS-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[PRE_ST+j-1]) begin
        for (int l = 0; l < 3; l++) begin
          if (take[l]) begin
            rr[j][l] <= dif[l];
            pp[j][l] <= pp[j-1][l] + (PW'(ssum[j-1]) << (B + 1));
            kk[j][l] <= kk[j-1][l] | (ITERS'(1) << B);
          end else begin
            rr[j][l] <= rr[j-1][l];
            pp[j][l] <= pp[j-1][l];
            kk[j][l] <= kk[j-1][l];
          end
        end
        ssum[j] <= ssum[j-1];
        negi[j] <= negi[j-1];
        deg[j]  <= deg[j-1];
      end
    end
  end

  // apply sign, force zeros on a degenerate triangle
  always_ff @(posedge clk) begin
    if (en[OST]) begin
      for (int l = 0; l < 3; l++) begin
        if (deg[ITERS]) begin
          norm[l] <= '0;
        end else if (negi[ITERS][l]) begin
          norm[l] <= NORM_W'(0) - NORM_W'(kk[ITERS][l]);
        end else begin
          norm[l] <= NORM_W'(kk[ITERS][l]);
        end
      end
      deg_out <= deg[ITERS];
    end
  end

  assign m_tdata = {norm[2], norm[1], norm[0], idx[OST]};
  assign m_tuser = deg_out;

  `TUN_ASSERT(a_full_when_blocked, s_tready || (&vld), "input blocked with a pipeline hole")
  `TUN_ASSERT(a_deg_zero, !(vld[OST] && deg_out) || (norm[0] == '0 && norm[1] == '0 && norm[2] == '0), "degenerate result not zero")
  `TUN_ASSERT(a_unit_range, !vld[ITERS+PRE_ST-1] || (kk[ITERS][0] <= ITERS'(1 << FRAC_BITS) && kk[ITERS][1] <= ITERS'(1 << FRAC_BITS) && kk[ITERS][2] <= ITERS'(1 << FRAC_BITS)), "component above one")
  `TUN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule

// ===== sim/triangle_unit_normal_core_test.sv =====
// Testbench for the triangle unit normal core: random and directed triangles, checked result by result.
module triangle_unit_normal_core_test;
  import tun_pkg::*;

  localparam int CW      = 24;
  localparam int IN_W    = ((IDX_W + 9 * CW + 7) / 8) * 8;
  localparam int N_RAND  = 1850;
  localparam int WD_MAX  = 5000;
  localparam int HOLD_AT = 150;

  typedef struct {
    logic [31:0]          tag;
    logic signed [CW-1:0] v [9];
  } tri_t;

  typedef struct {
    logic [31:0]        tag;
    logic signed [31:0] n [3];
    logic               degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [IDX_W+3*NORM_W-1:0] m_tdata;
  logic m_tuser;

  tri_t    pending_tris[$];
  normal_t expected_normals[$];
  tri_t    cur_tri;
  int      sent = 0;
  int      received = 0;
  int      errors = 0;
  int      quiet_cycles = 0;
  int      hold_left = 0;
  bit      held = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  triangle_unit_normal_core #(.COORD_WIDTH(CW)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // round(|c| * 2^30 / sqrt(s)), ties away from zero, sign of c
  function automatic logic signed [31:0] unit_part(longint c, logic [255:0] len_sq);
    logic [255:0] mag, rhs, odd;
    logic [31:0] k, t;
    mag = (c < 0) ? 256'(-c) : 256'(c);
    rhs = (mag * mag) << RHS_SHIFT;
    k = 0;
    for (int b = FRAC_BITS; b >= 0; b--) begin
      t = k | (32'd1 << b);
      if (t <= (32'd1 << FRAC_BITS)) begin
        odd = 256'(2 * t - 1);
        if (odd * odd * len_sq <= rhs) k = t;
      end
    end
    return (c < 0) ? -k : k;
  endfunction

  function automatic normal_t face_normal(tri_t tr);
    normal_t r;
    longint u[3], w[3], cr[3];
    logic [255:0] len_sq;
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'(tr.v[3+i]) - longint'(tr.v[i]);
      w[i] = longint'(tr.v[6+i]) - longint'(tr.v[i]);
    end
    cr[0] = u[1] * w[2] - u[2] * w[1];
    cr[1] = u[2] * w[0] - u[0] * w[2];
    cr[2] = u[0] * w[1] - u[1] * w[0];
    len_sq = 0;
    for (int i = 0; i < 3; i++) begin
      len_sq += (cr[i] < 0 ? 256'(-cr[i]) : 256'(cr[i])) ** 2;
    end
    r.tag = tr.tag;
    r.degen = (len_sq == 0);
    for (int i = 0; i < 3; i++) r.n[i] = r.degen ? 32'sd0 : unit_part(cr[i], len_sq);
    return r;
  endfunction

  function automatic int idle_pct(int n, bit sender);
    case ((n / 300) % 4)
      0: return 0;
      1: return sender ? 58 : 0;
      2: return sender ? 0 : 58;
      default: return 34;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_normals.push_back(face_normal(cur_tri));
        sent <= sent + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_tris.size() > 0 && $urandom_range(99) >= idle_pct(sent, 1'b1)) begin
          tri_t tr;
          tr = pending_tris.pop_front();
          cur_tri <= tr;
          s_tdata <= {tr.v[8], tr.v[7], tr.v[6], tr.v[5], tr.v[4], tr.v[3],
                      tr.v[2], tr.v[1], tr.v[0], tr.tag};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        normal_t got, exp_n;
        got.tag = m_tdata[31:0];
        got.n[0] = m_tdata[63:32];
        got.n[1] = m_tdata[95:64];
        got.n[2] = m_tdata[127:96];
        got.degen = m_tuser;
        received <= received + 1;
        if (expected_normals.size() == 0) begin
          $display("%0t: unexpected result tag %h", $time, got.tag);
          errors++;
        end else begin
          exp_n = expected_normals.pop_front();
          if (got.tag !== exp_n.tag) begin
            $display("%0t: out_index expected %h actual %h", $time, exp_n.tag, got.tag);
            errors++;
          end
          for (int i = 0; i < 3; i++) begin
            if (got.n[i] !== exp_n.n[i]) begin
              $display("%0t: tag %h norm[%0d] expected %0d actual %0d", $time, exp_n.tag, i,
                       exp_n.n[i], got.n[i]);
              errors++;
            end
          end
          if (got.degen !== exp_n.degen) begin
            $display("%0t: tag %h degenerate expected %b actual %b", $time, exp_n.tag,
                     exp_n.degen, got.degen);
            errors++;
          end
        end
      end
      // one long hold-off while the sender keeps offering, to fill the pipeline
      if (!held && received >= HOLD_AT) begin
        held <= 1'b1;
        hold_left <= 400;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= idle_pct(received, 1'b0));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_MAX) begin
        $display("triangle_unit_normal_core_test: errors");
        $finish;
      end
    end
  end

  task automatic add_tri(logic [31:0] tag, int ax, int ay, int az, int bx, int by, int bz,
                         int cx, int cy, int cz);
    tri_t tr;
    tr.tag = tag;
    tr.v[0] = CW'(ax); tr.v[1] = CW'(ay); tr.v[2] = CW'(az);
    tr.v[3] = CW'(bx); tr.v[4] = CW'(by); tr.v[5] = CW'(bz);
    tr.v[6] = CW'(cx); tr.v[7] = CW'(cy); tr.v[8] = CW'(cz);
    pending_tris.push_back(tr);
  endtask

  initial begin
    int lo, mode;
    tri_t tr;
    // degenerate: all zero, repeated vertex, collinear
    add_tri(32'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(32'hFFFF_FFFF, 5, 6, 7, 5, 6, 7, 9, 1, 2);
    add_tri(32'h1, 0, 0, 0, 1, 2, 3, 2, 4, 6);
    add_tri(32'h2, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 0, 0, 0);
    // axis-aligned normals, both signs
    add_tri(32'h3, 0, 0, 0, 4096, 0, 0, 0, 4096, 0);
    add_tri(32'h4, 0, 0, 0, 0, 4096, 0, 4096, 0, 0);
    add_tri(32'h5, 0, 0, 0, 0, 1, 0, 0, 0, 1);
    add_tri(32'h6, 0, 0, 0, 0, 0, 1, 1, 0, 0);
    add_tri(32'h7, 7, 7, 7, 7, 7, 8, 7, 6, 7);
    // extremes of the coordinate range, then small and mixed triangles
    add_tri(32'h8, -8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
            -8388608, 8388607, 8388607);
    add_tri(32'h9, 8388607, 8388607, 8388607, -8388608, 8388607, -8388608,
            8388607, -8388608, -8388608);
    add_tri(32'hA, 8388607, -8388608, 0, -8388608, 0, 8388607, 0, 8388607, -8388608);
    add_tri(32'hB, 0, 0, 0, 1, 1, 0, 1, 0, 1);
    add_tri(32'hC, 0, 0, 0, 3, 0, 0, 0, 4, 0);
    add_tri(32'hD, 1, 2, 3, 4, 6, 8, -3, 5, 11);
    add_tri(32'h8000_0000, -1, -1, -1, 0, -1, -1, -1, 0, -1);
    for (int i = 0; i < N_RAND; i++) begin
      mode = $urandom_range(9);
      tr.tag = $urandom;
      if (mode == 0) begin
        // thin or collinear triangles
        for (int j = 0; j < 3; j++) tr.v[j] = CW'($urandom);
        for (int j = 0; j < 3; j++) tr.v[3+j] = tr.v[j] + CW'($urandom_range(7) * 3);
        for (int j = 0; j < 3; j++) tr.v[6+j] = tr.v[j] + CW'($urandom_range(7) * 5);
        if ($urandom_range(1)) for (int j = 0; j < 3; j++) tr.v[6+j] = tr.v[3+j];
      end else begin
        lo = (mode < 4) ? -64 : -8388608;
        for (int j = 0; j < 9; j++) begin
          tr.v[j] = (mode < 4) ? CW'($urandom_range(127) + lo) : CW'($urandom);
        end
      end
      pending_tris.push_back(tr);
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_tris.size() == 0 && !s_tvalid && expected_normals.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("triangle_unit_normal_core_test: clean");
    end else begin
      $display("triangle_unit_normal_core_test: errors");
    end
    $finish;
  end

endmodule
